@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_DIS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_DIS(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/ers_pkg.sv @@
package ers_pkg;

    localparam int GRP_W = 8;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_STAND = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_RANGE = 2'd2,
        ST_IDLE  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_TOP    = 1'b0,
        CFG_BOTTOM = 1'b1
    } t_cfg_idx;

    localparam logic signed [5:0] TOP_RESET = 6'sd17;
    localparam logic signed [5:0] BOT_RESET = -6'sd3;

    typedef struct packed {
        logic load;
        logic eval;
        logic scan1;
        logic scan2;
    } t_cmd;

    typedef struct packed {
        logic need_pick;
    } t_sts;

    function automatic logic [2:0] lowest8(input logic [GRP_W-1:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] highest8(input logic [GRP_W-1:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < GRP_W; i++) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/elevator_request_scheduler_unit.sv @@
// o_done strobes after S_EVAL, or after S_SCAN1 and S_SCAN2 when the target search runs.
// The search runs on an accepted press while standing and on every arrival while moving.
// One item at a time: start is taken again the cycle after o_done.
// Reset (synchronous, active low): request maps clear, car stands at floor 0,
// top floor 17, bottom floor -3. The receiver cannot stall; each result shows one cycle.
`include "assert_macros.svh"

module elevator_request_scheduler_unit #(
    parameter int FLOOR_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_idx,
    input  logic [5:0]        i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic signed [5:0] i_floor,
    input  logic              i_want_up,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [1:0]        o_direction,
    output logic signed [5:0] o_target_floor,
    output logic signed [5:0] o_current_floor
);
    import ers_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ers_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    ers_dpath #(
        .FLOOR_SLOTS (FLOOR_SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_floor         (i_floor),
        .i_want_up       (i_want_up),
        .o_status        (o_status),
        .o_direction     (o_direction),
        .o_target_floor  (o_target_floor),
        .o_current_floor (o_current_floor)
    );

    `ASSERT_DIS(a_accept_busy, i_clk, i_rst_n,
                (start && !busy) |=> busy, "accepted item did not raise busy")
    `ASSERT_DIS(a_done_idle, i_clk, i_rst_n,
                o_done |=> !busy, "block not idle after result")
    `ASSERT_DIS(a_scan_done, i_clk, i_rst_n,
                w_cmd.scan2 |=> o_done, "target pick not followed by result")
    `ASSERT_DIS(a_stand_target, i_clk, i_rst_n,
                (o_done && (o_direction == DIR_STAND)) |-> (o_target_floor == o_current_floor),
                "standing target differs from car floor")

endmodule

@@ hw/rtl/ers_ctrl.sv @@
module ers_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ers_pkg::t_sts i_sts,
    output logic          o_busy,
    output logic          o_done,
    output ers_pkg::t_cmd o_cmd
);
    import ers_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_SCAN1 = 5'b00100,
        S_SCAN2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_sts.need_pick ? S_SCAN1 : S_DONE;
            end
            S_SCAN1: n_state = S_SCAN2;
            S_SCAN2: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_cmd.load  = (r_state == S_IDLE) && i_start;
    assign o_cmd.eval  = (r_state == S_EVAL);
    assign o_cmd.scan1 = (r_state == S_SCAN1);
    assign o_cmd.scan2 = (r_state == S_SCAN2);

endmodule

@@ hw/rtl/ers_dpath.sv @@
module ers_dpath #(
    parameter int FLOOR_SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ers_pkg::t_cmd      i_cmd,
    output ers_pkg::t_sts      o_sts,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_kind,
    input  logic signed [5:0]  i_floor,
    input  logic               i_want_up,
    output logic [1:0]         o_status,
    output logic [1:0]         o_direction,
    output logic signed [5:0]  o_target_floor,
    output logic signed [5:0]  o_current_floor
);
    import ers_pkg::*;

    localparam int HALF   = FLOOR_SLOTS / 2;
    localparam int SLOT_W = $clog2(FLOOR_SLOTS);
    localparam int N_GRP  = (FLOOR_SLOTS + GRP_W - 1) / GRP_W;
    localparam int PAD_W  = N_GRP * GRP_W;
    localparam int GI_W   = (N_GRP > 1) ? $clog2(N_GRP) : 1;

    logic signed [5:0]      r_top;
    logic signed [5:0]      r_bot;
    logic                   r_kind;
    logic signed [5:0]      r_floor;
    logic                   r_want_up;
    logic [FLOOR_SLOTS-1:0] r_up;
    logic [FLOOR_SLOTS-1:0] r_dn;
    t_dir                   r_dir;
    logic signed [5:0]      r_car;
    logic signed [5:0]      r_goal;
    t_status                r_status;
    logic                   r_pref_up;
    logic [N_GRP-1:0]       r_gany_up;
    logic [N_GRP-1:0]       r_gany_dn;
    logic [2:0]             r_glo_up [N_GRP];
    logic [2:0]             r_ghi_dn [N_GRP];

    logic [7:0]        w_slot;
    logic [7:0]        w_gslot;
    logic              w_slot_ok;
    logic              w_gslot_ok;
    logic [SLOT_W-1:0] w_idx;
    logic [SLOT_W-1:0] w_gidx;
    logic              w_standing;
    logic              w_end;
    logic              w_range;
    t_status           w_status;
    logic              w_need_pick;
    logic              w_pref_up;
    logic [PAD_W-1:0]  w_up_pad;
    logic [PAD_W-1:0]  w_dn_pad;
    logic [GI_W-1:0]   w_lo_grp;
    logic [GI_W-1:0]   w_hi_grp;
    logic              w_up_any;
    logic              w_dn_any;
    logic [7:0]        w_up_slot;
    logic [7:0]        w_dn_slot;
    logic signed [5:0] w_up_floor;
    logic signed [5:0] w_dn_floor;

    always_comb begin
        w_slot     = {{2{r_floor[5]}}, r_floor} + 8'(HALF);
        w_gslot    = {{2{r_goal[5]}}, r_goal} + 8'(HALF);
        w_slot_ok  = !w_slot[7] && (w_slot < 8'(FLOOR_SLOTS));
        w_gslot_ok = !w_gslot[7] && (w_gslot < 8'(FLOOR_SLOTS));
        w_idx      = w_slot[SLOT_W-1:0];
        w_gidx     = w_gslot[SLOT_W-1:0];
        w_standing = (r_dir != DIR_UP) && (r_dir != DIR_DOWN);
        w_end      = (r_want_up && (r_floor == r_top)) || (!r_want_up && (r_floor == r_bot));
        w_range    = (r_floor < r_bot) || (r_floor > r_top) || !w_slot_ok;
        if (r_kind) begin
            w_status    = w_standing ? ST_IDLE : ST_OK;
            w_need_pick = !w_standing;
            w_pref_up   = (r_dir == DIR_UP);
        end else begin
            w_status    = w_end ? ST_END : (w_range ? ST_RANGE : ST_OK);
            w_need_pick = !w_end && !w_range && w_standing;
            w_pref_up   = 1'b1;
        end
    end

    assign o_sts.need_pick = w_need_pick;
    assign w_up_pad = PAD_W'(r_up);
    assign w_dn_pad = PAD_W'(r_dn);

    always_comb begin
        w_lo_grp = '0;
        w_hi_grp = '0;
        for (int g = N_GRP - 1; g >= 0; g--) begin
            if (r_gany_up[g]) begin
                w_lo_grp = GI_W'(g);
            end
        end
        for (int g = 0; g < N_GRP; g++) begin
            if (r_gany_dn[g]) begin
                w_hi_grp = GI_W'(g);
            end
        end
        w_up_any   = |r_gany_up;
        w_dn_any   = |r_gany_dn;
        w_up_slot  = 8'({w_lo_grp, r_glo_up[w_lo_grp]});
        w_dn_slot  = 8'({w_hi_grp, r_ghi_dn[w_hi_grp]});
        w_up_floor = 6'(w_up_slot - 8'(HALF));
        w_dn_floor = 6'(w_dn_slot - 8'(HALF));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_RESET;
            r_bot <= BOT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOP:    r_top <= i_cfg_data;
                CFG_BOTTOM: r_bot <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_floor   <= i_floor;
            r_want_up <= i_want_up;
        end
        if (i_cmd.eval) begin
            r_status  <= w_status;
            r_pref_up <= w_pref_up;
        end
        if (i_cmd.scan1) begin
            for (int g = 0; g < N_GRP; g++) begin
                r_gany_up[g] <= |w_up_pad[g*GRP_W +: GRP_W];
                r_gany_dn[g] <= |w_dn_pad[g*GRP_W +: GRP_W];
                r_glo_up[g]  <= lowest8(w_up_pad[g*GRP_W +: GRP_W]);
                r_ghi_dn[g]  <= highest8(w_dn_pad[g*GRP_W +: GRP_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up   <= '0;
            r_dn   <= '0;
            r_dir  <= DIR_STAND;
            r_car  <= '0;
            r_goal <= '0;
        end else if (i_cmd.eval) begin
            if (r_kind) begin
                if (!w_standing) begin
                    r_car <= r_goal;
                    if (w_gslot_ok) begin
                        if (r_dir == DIR_UP) begin
                            r_up[w_gidx] <= 1'b0;
                        end else begin
                            r_dn[w_gidx] <= 1'b0;
                        end
                    end
                end
            end else if (!w_end && !w_range) begin
                if (r_want_up) begin
                    r_up[w_idx] <= 1'b1;
                end else begin
                    r_dn[w_idx] <= 1'b1;
                end
            end
        end else if (i_cmd.scan2) begin
            if (r_pref_up) begin
                if (w_up_any) begin
                    r_dir  <= DIR_UP;
                    r_goal <= w_up_floor;
                end else if (w_dn_any) begin
                    r_dir  <= DIR_DOWN;
                    r_goal <= w_dn_floor;
                end else begin
                    r_dir <= DIR_STAND;
                end
            end else begin
                if (w_dn_any) begin
                    r_dir  <= DIR_DOWN;
                    r_goal <= w_dn_floor;
                end else if (w_up_any) begin
                    r_dir  <= DIR_UP;
                    r_goal <= w_up_floor;
                end else begin
                    r_dir <= DIR_STAND;
                end
            end
        end
    end

    assign o_status        = r_status;
    assign o_direction     = r_dir;
    assign o_target_floor  = w_standing ? r_car : r_goal;
    assign o_current_floor = r_car;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ers_pkg::*;

    localparam logic CALL_PRESS  = 1'b0;
    localparam logic CALL_ARRIVE = 1'b1;
    localparam logic WANT_DOWN   = 1'b0;
    localparam logic WANT_UP     = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic              kind;
        logic signed [5:0] floor;
        logic              want_up;
    } t_call;

    typedef struct packed {
        t_status           status;
        t_dir              direction;
        logic signed [5:0] target;
        logic signed [5:0] current;
    } t_car_view;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_idx = CFG_TOP;
    logic [5:0]        i_cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_kind = CALL_PRESS;
    logic signed [5:0] i_floor = '0;
    logic              i_want_up = WANT_DOWN;
    logic              o_done;
    logic [1:0]        o_status;
    logic [1:0]        o_direction;
    logic signed [5:0] o_target_floor;
    logic signed [5:0] o_current_floor;

    t_call     pending_calls[$];
    t_car_view awaited_views[$];
    t_call     call_now;
    t_car_view view_now;
    int        accepted_calls = 0;
    int        popped_calls = 0;
    int        checked_calls = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    logic [63:0]       up_calls = '0;
    logic [63:0]       down_calls = '0;
    t_dir              heading = DIR_STAND;
    logic signed [5:0] car_at = '0;
    logic signed [5:0] heading_to = '0;
    logic signed [5:0] cfg_top = TOP_RESET;
    logic signed [5:0] cfg_bottom = BOT_RESET;

    elevator_request_scheduler_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_floor         (i_floor),
        .i_want_up       (i_want_up),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_direction     (o_direction),
        .o_target_floor  (o_target_floor),
        .o_current_floor (o_current_floor)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [5:0] lowest_call_floor(input logic [63:0] map);
        logic signed [5:0] r;
        r = '0;
        for (int s = 63; s >= 0; s--) begin
            if (map[s]) begin
                r = 6'(s - 32);
            end
        end
        return r;
    endfunction

    function automatic logic signed [5:0] highest_call_floor(input logic [63:0] map);
        logic signed [5:0] r;
        r = '0;
        for (int s = 0; s < 64; s++) begin
            if (map[s]) begin
                r = 6'(s - 32);
            end
        end
        return r;
    endfunction

    function automatic void pick_heading(input logic up_first);
        if (up_calls != 0 && (up_first || down_calls == 0)) begin
            heading = DIR_UP;
            heading_to = lowest_call_floor(up_calls);
        end else if (down_calls != 0) begin
            heading = DIR_DOWN;
            heading_to = highest_call_floor(down_calls);
        end else begin
            heading = DIR_STAND;
        end
    endfunction

    function automatic t_car_view schedule_call(input t_call c);
        t_car_view   r;
        logic [63:0] slot_bit;
        r.status = ST_OK;
        if (c.kind == CALL_ARRIVE) begin
            if (heading == DIR_STAND) begin
                r.status = ST_IDLE;
            end else begin
                car_at = heading_to;
                slot_bit = 64'd1 << (int'(heading_to) + 32);
                if (heading == DIR_UP) begin
                    up_calls &= ~slot_bit;
                    pick_heading(1'b1);
                end else begin
                    down_calls &= ~slot_bit;
                    pick_heading(1'b0);
                end
            end
        end else if ((c.want_up && c.floor == cfg_top)
                     || (!c.want_up && c.floor == cfg_bottom)) begin
            r.status = ST_END;
        end else if (c.floor < cfg_bottom || c.floor > cfg_top) begin
            r.status = ST_RANGE;
        end else begin
            slot_bit = 64'd1 << (int'(c.floor) + 32);
            if (c.want_up) begin
                up_calls |= slot_bit;
            end else begin
                down_calls |= slot_bit;
            end
            if (heading == DIR_STAND) begin
                pick_heading(1'b1);
            end
        end
        r.direction = heading;
        r.target = (heading == DIR_STAND) ? car_at : heading_to;
        r.current = car_at;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                awaited_views.push_back(schedule_call('{i_kind, i_floor, i_want_up}));
                accepted_calls++;
            end
            if (pending_calls.size() != 0
                && ((accepted_calls >= 300 && accepted_calls < 420)
                    || $urandom_range(99) >= 19)) begin
                call_now = pending_calls.pop_front();
                popped_calls++;
                start <= 1'b1;
                i_kind <= call_now.kind;
                i_floor <= call_now.floor;
                i_want_up <= call_now.want_up;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            checked_calls++;
            if (awaited_views.size() == 0) begin
                $error("result with no item outstanding: status %0d direction %0d",
                       o_status, o_direction);
                mismatches++;
            end else begin
                view_now = awaited_views.pop_front();
                if (o_status !== view_now.status) begin
                    $error("status expected %0d got %0d", view_now.status, o_status);
                    mismatches++;
                end
                if (o_direction !== view_now.direction) begin
                    $error("direction expected %0d got %0d", view_now.direction, o_direction);
                    mismatches++;
                end
                if (o_target_floor !== view_now.target) begin
                    $error("target_floor expected %0d got %0d",
                           view_now.target, o_target_floor);
                    mismatches++;
                end
                if (o_current_floor !== view_now.current) begin
                    $error("current_floor expected %0d got %0d",
                           view_now.current, o_current_floor);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("elevator_request_scheduler_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_call(input logic kind, input logic signed [5:0] fl,
                              input logic up);
        pending_calls.push_back('{kind, fl, up});
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (pending_calls.size() != 0 || popped_calls != checked_calls || busy);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic signed [5:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == CFG_TOP) begin
            cfg_top = value;
        end else begin
            cfg_bottom = value;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic signed [5:0] top, input logic signed [5:0] bottom,
                             input int count);
        int                lo;
        int                hi;
        int                roll;
        logic signed [5:0] fl;
        write_reg(CFG_TOP, top);
        write_reg(CFG_BOTTOM, bottom);
        lo = bottom;
        hi = top;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            fl = 6'($urandom);
            if (roll < 30) begin
                queue_call(CALL_ARRIVE, fl, 1'($urandom));
            end else begin
                if (roll < 88 && hi >= lo) begin
                    fl = 6'(lo + $urandom_range(hi - lo));
                end
                queue_call(CALL_PRESS, fl, 1'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_call(CALL_ARRIVE, 0, WANT_UP);
        queue_call(CALL_PRESS, 17, WANT_UP);
        queue_call(CALL_PRESS, -3, WANT_DOWN);
        queue_call(CALL_PRESS, 31, WANT_UP);
        queue_call(CALL_PRESS, -32, WANT_DOWN);
        queue_call(CALL_PRESS, 18, WANT_DOWN);
        queue_call(CALL_PRESS, -4, WANT_UP);
        queue_call(CALL_PRESS, 0, WANT_UP);
        queue_call(CALL_PRESS, 12, WANT_DOWN);
        queue_call(CALL_PRESS, 17, WANT_DOWN);
        queue_call(CALL_PRESS, -3, WANT_UP);
        queue_call(CALL_PRESS, -3, WANT_UP);
        queue_call(CALL_ARRIVE, 31, WANT_DOWN);
        queue_call(CALL_ARRIVE, -32, WANT_UP);
        queue_call(CALL_PRESS, 5, WANT_UP);
        queue_call(CALL_ARRIVE, 0, WANT_UP);
        queue_call(CALL_ARRIVE, 0, WANT_DOWN);
        queue_call(CALL_ARRIVE, 0, WANT_UP);
        queue_call(CALL_ARRIVE, 0, WANT_UP);
        queue_call(CALL_PRESS, -1, WANT_DOWN);
        queue_call(CALL_ARRIVE, 0, WANT_DOWN);
        drain();

        run_phase(31, -32, 160);
        run_phase(5, -5, 100);
        run_phase(-32, 31, 40);
        run_phase(0, 0, 40);
        run_phase(31, 30, 50);
        run_phase(-30, -32, 50);
        run_phase(10, -20, 150);
        run_phase(TOP_RESET, BOT_RESET, 160);

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("elevator_request_scheduler_unit test passed");
        end else begin
            $display("elevator_request_scheduler_unit test failed");
        end
        $finish;
    end

endmodule
